[rtl/aml_pkg.sv]
// ----------------------------------------------------------------------------
// aml_pkg: shared types and constants for the accelerometer magnitude filter
// Field widths, filter constants and the command and status groups that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package aml_pkg;

   localparam int ACCEL_W = 16;
   localparam int TIME_W = 32;
   localparam int MAG_W = 24;
   localparam int ALPHA_W = 17;
   localparam int SUM_W = 32;
   localparam int FRACTION_BITS_DEFAULT = 8;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd6554;
   localparam logic [MAG_W-1:0] MAG_MAX = 24'hFFFFFF;

   // Operand pairs for the shared multiplier.
   typedef enum logic [2:0] {
      MUL_X,
      MUL_Y,
      MUL_Z,
      MUL_ALPHA,
      MUL_BETA
   } mul_sel_type;

   typedef struct packed {
      logic        load;       // capture a new sample, clear the sum
      logic        mul_en;     // register one product
      mul_sel_type mul_sel;
      logic        sum_add;    // add the last product into the sum of squares
      logic        root_load;  // start the square root
      logic        root_step;  // one result bit of the square root
      logic        acc_load;   // hold the alpha term of the filter
      logic        filt_done;  // form the smoothed value, update the memory
      logic        out_load;   // publish the result
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;          // the output register can take a result now
   } dp_status_type;

endpackage

[rtl/accel_magnitude_lowpass.sv]
// ----------------------------------------------------------------------------
// accel_magnitude_lowpass: accelerometer vector magnitude with low-pass filter
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Each input beat carries one signed three-axis sample and its timestamp and
// produces exactly one result beat: the floored magnitude
// sqrt((x*x + y*y + z*z) * 2^(2*FRACTION_BITS)) in unsigned fixed point with
// FRACTION_BITS fraction bits, a first-order low-pass of that magnitude
// rounded as (alpha*mag + (1-alpha)*previous + one half) in Q1.16, and the
// timestamp copied through. One sample is processed at a time: the sequencer
// squares the three axes, takes the bit-serial square root, applies the
// filter and publishes the result, and only then returns to idle to
// take the next sample. The root produces one result bit per cycle over
// 16 + FRACTION_BITS steps, and one shared multiplier forms the three squares
// and the two filter products in turn. A finished result sits in an output
// register, so a stalled result channel does not hold up the next sample
// until that sample itself is ready to publish. The filter weight
// csr_filter_alpha resets to 6554 (about 0.1); values above 65536 act as
// 65536, which passes the magnitude through unfiltered. The configuration
// channel is ready whenever reset is low and should be written only while
// the block is idle. The filter memory resets to zero.
// ----------------------------------------------------------------------------
module accel_magnitude_lowpass
   import aml_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // Sample channel.
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [ACCEL_W-1:0] req_accel_x,
   input  logic signed [ACCEL_W-1:0] req_accel_y,
   input  logic signed [ACCEL_W-1:0] req_accel_z,
   input  logic [TIME_W-1:0]         req_sample_time,
   // Result channel.
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [MAG_W-1:0]          rsp_magnitude,
   output logic [MAG_W-1:0]          rsp_smoothed_magnitude,
   output logic [TIME_W-1:0]         rsp_result_time,
   // Filter weight register.
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [ALPHA_W-1:0]        csr_filter_alpha
);

   dp_cmd_type cmd;
   dp_status_type status;

   // The register takes a write in any cycle outside reset.
   assign csr_ready = !reset;

   // The sequencer decides which datapath step runs in each cycle.
   aml_ctrl #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   // The datapath holds the sample, the root, the filter memory and the
   // output register.
   aml_datapath #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_accel_x           (req_accel_x),
      .req_accel_y           (req_accel_y),
      .req_accel_z           (req_accel_z),
      .req_sample_time       (req_sample_time),
      .csr_write             (csr_valid && csr_ready),
      .csr_filter_alpha      (csr_filter_alpha),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_magnitude         (rsp_magnitude),
      .rsp_smoothed_magnitude(rsp_smoothed_magnitude),
      .rsp_result_time       (rsp_result_time)
   );

endmodule

[rtl/aml_ctrl.sv]
// ----------------------------------------------------------------------------
// aml_ctrl: sequencer for the accelerometer magnitude filter
// Walks each sample through squaring, the bit-serial root and the filter.
// ----------------------------------------------------------------------------
module aml_ctrl
   import aml_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam int ROOT_W = 16 + FRACTION_BITS;
   localparam int CNT_W = $clog2(ROOT_W);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_Z,
      ST_SQ_SUM,
      ST_ROOT_LOAD,
      ST_ROOT,
      ST_FILT_A,
      ST_FILT_B,
      ST_FILT_C,
      ST_PUBLISH
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      cmd = '0;
      cmd.mul_sel = MUL_X;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SQ_X;
            end
         end
         ST_SQ_X: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MUL_X;
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MUL_Y;
            cmd.sum_add = 1'b1;
            state_in = ST_SQ_Z;
         end
         ST_SQ_Z: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MUL_Z;
            cmd.sum_add = 1'b1;
            state_in = ST_SQ_SUM;
         end
         ST_SQ_SUM: begin
            cmd.sum_add = 1'b1;
            state_in = ST_ROOT_LOAD;
         end
         ST_ROOT_LOAD: begin
            cmd.root_load = 1'b1;
            cnt_in = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
               state_in = ST_FILT_A;
            end
         end
         ST_FILT_A: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MUL_ALPHA;
            state_in = ST_FILT_B;
         end
         ST_FILT_B: begin
            cmd.acc_load = 1'b1;
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MUL_BETA;
            state_in = ST_FILT_C;
         end
         ST_FILT_C: begin
            cmd.filt_done = 1'b1;
            state_in = ST_PUBLISH;
         end
         ST_PUBLISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // No sample is taken while reset is held.
   assign req_stall = reset || (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

[rtl/aml_datapath.sv]
// ----------------------------------------------------------------------------
// aml_datapath: arithmetic and storage for the accelerometer magnitude filter
// Shared multiplier, sum of squares, bit-serial root, filter and result beat.
// ----------------------------------------------------------------------------
module aml_datapath
   import aml_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   output dp_status_type            status,
   input  logic signed [ACCEL_W-1:0] req_accel_x,
   input  logic signed [ACCEL_W-1:0] req_accel_y,
   input  logic signed [ACCEL_W-1:0] req_accel_z,
   input  logic [TIME_W-1:0]        req_sample_time,
   input  logic                     csr_write,
   input  logic [ALPHA_W-1:0]       csr_filter_alpha,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [MAG_W-1:0]         rsp_magnitude,
   output logic [MAG_W-1:0]         rsp_smoothed_magnitude,
   output logic [TIME_W-1:0]        rsp_result_time
);

   localparam int ROOT_W = 16 + FRACTION_BITS;
   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;
   localparam int WIDE_W = (ROOT_W > MAG_W) ? ROOT_W : MAG_W;
   localparam int MUL_B_W = MAG_W;
   localparam int PROD_W = ALPHA_W + MUL_B_W;
   localparam int ACC_W = PROD_W + 1;
   localparam int SMOOTH_W = ACC_W - 16;

   logic [ALPHA_W-1:0] alpha_ff;
   logic [ACCEL_W-1:0] abs_x_ff, abs_y_ff, abs_z_ff;
   logic [TIME_W-1:0] time_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [PROD_W-1:0] prod_ff, acc_ff;
   logic [RAD_W-1:0] rad_ff;
   logic [REM_W-1:0] rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [MAG_W-1:0] mag_ff, mem_ff;
   logic rsp_valid_ff;
   logic [MAG_W-1:0] out_mag_ff, out_smooth_ff;
   logic [TIME_W-1:0] out_time_ff;

   logic [ALPHA_W-1:0] alpha_eff, beta;
   logic [ALPHA_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [WIDE_W-1:0] root_wide;
   logic [MAG_W-1:0] mag_sat;
   logic [REM_W-1:0] rem_shift, trial, rem_diff;
   logic [ACC_W-1:0] acc_sum;
   logic [SMOOTH_W-1:0] smooth_full;
   logic [MAG_W-1:0] smooth_sat;

   function automatic logic [ACCEL_W-1:0] abs16(input logic signed [ACCEL_W-1:0] v);
      abs16 = v[ACCEL_W-1] ? (~v + 1'b1) : v;
   endfunction

   // Weights above one are treated as one.
   assign alpha_eff = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
   assign beta = ALPHA_ONE - alpha_eff;

   // Saturate the root to the magnitude field.
   assign root_wide = WIDE_W'(root_ff);
   assign mag_sat = (root_wide > WIDE_W'(MAG_MAX)) ? MAG_MAX : root_wide[MAG_W-1:0];

   always_comb begin
      case (cmd.mul_sel)
         MUL_X: begin
            mul_a = ALPHA_W'(abs_x_ff);
            mul_b = MUL_B_W'(abs_x_ff);
         end
         MUL_Y: begin
            mul_a = ALPHA_W'(abs_y_ff);
            mul_b = MUL_B_W'(abs_y_ff);
         end
         MUL_Z: begin
            mul_a = ALPHA_W'(abs_z_ff);
            mul_b = MUL_B_W'(abs_z_ff);
         end
         MUL_ALPHA: begin
            mul_a = alpha_eff;
            mul_b = mag_sat;
         end
         MUL_BETA: begin
            mul_a = beta;
            mul_b = mem_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // One root bit per step: bring down two radicand bits and try 4*root+1.
   assign rem_shift = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial = {root_ff, 2'b01};
   assign rem_diff = rem_shift - trial;

   assign acc_sum = ACC_W'(acc_ff) + ACC_W'(prod_ff) + ACC_W'(32768);
   assign smooth_full = acc_sum[ACC_W-1:16];
   assign smooth_sat = (smooth_full > SMOOTH_W'(MAG_MAX)) ? MAG_MAX
                                                          : smooth_full[MAG_W-1:0];

   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
         mem_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            alpha_ff <= csr_filter_alpha;
         end
         if (cmd.filt_done) begin
            mem_ff <= smooth_sat;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         abs_x_ff <= abs16(req_accel_x);
         abs_y_ff <= abs16(req_accel_y);
         abs_z_ff <= abs16(req_accel_z);
         time_ff <= req_sample_time;
         sum_ff <= '0;
      end else if (cmd.sum_add) begin
         sum_ff <= sum_ff + prod_ff[SUM_W-1:0];
      end
      if (cmd.mul_en) begin
         prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
      if (cmd.root_load) begin
         rad_ff <= RAD_W'(sum_ff) << (2 * FRACTION_BITS);
         rem_ff <= '0;
         root_ff <= '0;
      end else if (cmd.root_step) begin
         rad_ff <= rad_ff << 2;
         if (rem_shift >= trial) begin
            rem_ff <= rem_diff;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_shift;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
      if (cmd.mul_en && cmd.mul_sel == MUL_ALPHA) begin
         mag_ff <= mag_sat;
      end
      if (cmd.acc_load) begin
         acc_ff <= prod_ff;
      end
      if (cmd.out_load) begin
         out_mag_ff <= mag_ff;
         out_smooth_ff <= mem_ff;
         out_time_ff <= time_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_magnitude = out_mag_ff;
   assign rsp_smoothed_magnitude = out_smooth_ff;
   assign rsp_result_time = out_time_ff;

endmodule

[tb/accel_magnitude_lowpass_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// accel_magnitude_lowpass_tb: self-checking bench for the magnitude filter
// Drives signed three-axis samples with timestamps, predicts the floored
// magnitude, the low-pass output and the copied timestamp for every accepted
// sample, and checks each result beat against the oldest prediction. Both
// channels idle and stall at random, and the filter weight is rewritten
// between phases.
// ----------------------------------------------------------------------------
module accel_magnitude_lowpass_tb
   import aml_pkg::*;
;

   // The bit-serial root takes most of the time from a sample to its result.
   localparam int FRAC_BITS = FRACTION_BITS_DEFAULT;
   localparam int LATENCY = 25 + FRAC_BITS + 1;
   // Length of the long result hold-off that backs the block up.
   localparam int HOLD_CYCLES = 300;
   // Cycles with no beat accepted on any channel before the run is abandoned.
   // The worst honest gap is the hold-off plus one sample and some stalls.
   localparam int WATCHDOG_LIMIT = 2000;
   // Percentage of cycles in which each side idles when idling is enabled.
   localparam int IDLE_PERCENT = 28;
   localparam int PHASE_ITEMS = 260;

   typedef struct packed {
      logic [MAG_W-1:0]  magnitude;
      logic [MAG_W-1:0]  smoothed;
      logic [TIME_W-1:0] stamp;
   } accel_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [ACCEL_W-1:0] req_accel_x = '0;
   logic signed [ACCEL_W-1:0] req_accel_y = '0;
   logic signed [ACCEL_W-1:0] req_accel_z = '0;
   logic [TIME_W-1:0]         req_sample_time = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [MAG_W-1:0]          rsp_magnitude;
   logic [MAG_W-1:0]          rsp_smoothed_magnitude;
   logic [TIME_W-1:0]         rsp_result_time;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [ALPHA_W-1:0]        csr_filter_alpha = '0;

   // Our own copy of the block's state: the filter weight and the memory.
   logic [ALPHA_W-1:0] alpha_weight = ALPHA_RESET;
   logic [MAG_W-1:0]   filter_memory = '0;

   // Predicted result beats, oldest first.
   accel_result_type pending_results[$];

   // Idling controls: no_idle for both sides, the hold for the receiver alone.
   bit no_idle = 1'b0;
   bit hold_request = 1'b0;
   int hold_cycles_left = 0;

   int errors = 0;
   int samples_sent = 0;
   int results_checked = 0;
   int csr_writes = 0;
   int input_stall_cycles = 0;
   int quiet_cycles = 0;

   accel_magnitude_lowpass #(
      .FRACTION_BITS(FRAC_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_accel_x(req_accel_x),
      .req_accel_y(req_accel_y),
      .req_accel_z(req_accel_z),
      .req_sample_time(req_sample_time),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_magnitude(rsp_magnitude),
      .rsp_smoothed_magnitude(rsp_smoothed_magnitude),
      .rsp_result_time(rsp_result_time),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_filter_alpha(csr_filter_alpha)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Floor square root found one result bit at a time from the top: a bit is
   // kept when the trial root squared still does not exceed the radicand.
   // Roots wider than the magnitude field saturate at all ones.
   function automatic logic [MAG_W-1:0] floor_root(input logic [63:0] radicand);
      logic [31:0] root;
      logic [31:0] trial;
      logic [63:0] square;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
         trial = root | (32'd1 << i);
         square = {32'd0, trial} * {32'd0, trial};
         if (square <= radicand) begin
            root = trial;
         end
      end
      if (root > {8'd0, MAG_MAX}) begin
         return MAG_MAX;
      end
      return root[MAG_W-1:0];
   endfunction

   // Works out the result beat for one sample and advances the filter memory.
   // The weight is clamped to one, and the rounded filter output saturates
   // like the magnitude does.
   function automatic accel_result_type filter_sample(
      input logic signed [ACCEL_W-1:0] ax,
      input logic signed [ACCEL_W-1:0] ay,
      input logic signed [ACCEL_W-1:0] az,
      input logic [TIME_W-1:0]         stamp
   );
      longint             sx, sy, sz;
      longint unsigned    sum_sq, new_weight, old_weight, acc, smooth;
      accel_result_type   res;
      sx = ax;
      sy = ay;
      sz = az;
      sum_sq = longint'(sx * sx + sy * sy + sz * sz);
      res.magnitude = floor_root(sum_sq << (2 * FRAC_BITS));
      new_weight = (alpha_weight > ALPHA_ONE) ? ALPHA_ONE : alpha_weight;
      old_weight = longint'(ALPHA_ONE) - new_weight;
      acc = new_weight * res.magnitude + old_weight * filter_memory + 64'd32768;
      smooth = acc >> 16;
      if (smooth > MAG_MAX) begin
         smooth = MAG_MAX;
      end
      res.smoothed = smooth[MAG_W-1:0];
      res.stamp = stamp;
      filter_memory = res.smoothed;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Sample channel
   // ------------------------------------------------------------------------

   // Offers one sample and returns at the edge that accepts it. The valid
   // line is left high so that a following sample can go out back to back;
   // it is only lowered at the start of an idle gap or when draining.
   task automatic send_sample(
      input logic signed [ACCEL_W-1:0] ax,
      input logic signed [ACCEL_W-1:0] ay,
      input logic signed [ACCEL_W-1:0] az,
      input logic [TIME_W-1:0]         stamp
   );
      int gap;
      gap = 0;
      if (!no_idle) begin
         while ($urandom_range(99) < IDLE_PERCENT && gap < 12) begin
            gap++;
         end
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_accel_x <= ax;
      req_accel_y <= ay;
      req_accel_z <= az;
      req_sample_time <= stamp;
      @(posedge clock);
      while (req_stall) begin
         input_stall_cycles++;
         @(posedge clock);
      end
      // Accepted at this edge: the prediction goes in at acceptance order.
      pending_results.push_back(filter_sample(ax, ay, az, stamp));
      samples_sent++;
   endtask

   // Axis values are drawn from a mix of small magnitudes of either sign,
   // values close to the two extremes, and the full range.
   function automatic logic signed [ACCEL_W-1:0] pick_axis();
      logic [ACCEL_W-1:0] v;
      case ($urandom_range(3))
         0: v = ACCEL_W'($urandom_range(255));
         1: v = ACCEL_W'($urandom_range(65535, 65280));
         2: begin
            if ($urandom_range(1) == 1) begin
               v = 16'h8000 + ACCEL_W'($urandom_range(15));
            end else begin
               v = 16'h7FFF - ACCEL_W'($urandom_range(15));
            end
         end
         default: v = ACCEL_W'($urandom());
      endcase
      return v;
   endfunction

   task automatic send_random_samples(input int count);
      repeat (count) begin
         send_sample(pick_axis(), pick_axis(), pick_axis(), $urandom());
      end
   endtask

   // Lowers valid and waits until every predicted result has come back, so
   // that the block is idle.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // ------------------------------------------------------------------------
   // Filter weight register
   // ------------------------------------------------------------------------

   // Writes the weight once the block is idle and mirrors it in the predictor.
   task automatic write_filter_alpha(input logic [ALPHA_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_filter_alpha <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      alpha_weight = value;
      csr_writes++;
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Result channel: stall generator and checker
   // ------------------------------------------------------------------------

   // The receiver stalls at random, never during the steady stretch, and holds
   // off in one unbroken run when a hold is requested. The hold is counted
   // here, independent of what the sender is doing.
   always @(posedge clock) begin
      if (hold_cycles_left > 0) begin
         hold_cycles_left--;
         rsp_stall <= 1'b1;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_cycles_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (no_idle) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   task automatic check_field(
      input string       label,
      input logic [31:0] want,
      input logic [31:0] got
   );
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
                  $time, label, want, want, got, got);
         errors++;
      end
   endtask

   // Every result beat is compared field by field with the oldest prediction.
   always @(posedge clock) begin : result_check
      accel_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t ns: unexpected result beat, expected none, actual mag %0d time %0d",
                     $time, rsp_magnitude, rsp_result_time);
            errors++;
         end else begin
            want = pending_results.pop_front();
            check_field("magnitude", 32'(want.magnitude), 32'(rsp_magnitude));
            check_field("smoothed_magnitude", 32'(want.smoothed),
                        32'(rsp_smoothed_magnitude));
            check_field("result_time", want.stamp, rsp_result_time);
            results_checked++;
         end
      end
   end

   // Watchdog: counts cycles in which no channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no beat accepted for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, pending_results.size());
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Field extremes and bit patterns under the weight left by reset, which
   // also confirms the reset value of the register and of the filter memory.
   task automatic test_reset_weight_extremes();
      send_sample(16'sd0, 16'sd0, 16'sd0, 32'd0);
      send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 32'hFFFF_FFFF);
      send_sample(16'sd32767, 16'sd32767, 16'sd32767, 32'd1);
      send_sample(-16'sd32768, 16'sd0, 16'sd0, 32'h8000_0000);
      send_sample(16'sd0, 16'sd32767, 16'sd0, 32'h7FFF_FFFF);
      send_sample(16'sd0, 16'sd0, -16'sd32768, 32'h5555_5555);
      send_sample(16'sd1, 16'sd0, 16'sd0, 32'hAAAA_AAAA);
      send_sample(-16'sd1, -16'sd1, -16'sd1, 32'h0000_FFFF);
      send_sample(16'sh5555, 16'shAAAA, 16'sh5555, 32'hFFFF_0000);
      send_sample(-16'sd32768, 16'sd32767, -16'sd1, 32'h1234_5678);
   endtask

   // Weights of one and above act as one: the output follows the magnitude.
   task automatic test_alpha_above_one();
      write_filter_alpha({ALPHA_W{1'b1}});
      send_sample(16'sd300, -16'sd400, 16'sd1200, 32'd10);
      send_sample(-16'sd32768, 16'sd5, 16'sd0, 32'd11);
      send_sample(16'sd7, 16'sd0, -16'sd9, 32'd12);
      write_filter_alpha(ALPHA_ONE + 1'b1);
      send_sample(16'sd12000, 16'sd0, 16'sd0, 32'd13);
      send_sample(16'sd0, -16'sd3, 16'sd4, 32'd14);
      write_filter_alpha(ALPHA_ONE);
      send_sample(16'sd32767, -16'sd32768, 16'sd32767, 32'd15);
      send_sample(16'sd1, 16'sd1, 16'sd1, 32'd16);
   endtask

   // A zero weight freezes the filter output at its last value.
   task automatic test_alpha_zero();
      write_filter_alpha('0);
      send_sample(16'sd0, 16'sd0, 16'sd0, 32'd20);
      send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 32'd21);
      send_sample(16'sd100, 16'sd200, 16'sd300, 32'd22);
   endtask

   // Random samples under a spread of weights: the smallest step, just below
   // one, one half, random in range, random above one, and any 17-bit value.
   task automatic test_random_weights();
      logic [ALPHA_W-1:0] settings[6];
      settings[0] = ALPHA_W'(1);
      settings[1] = ALPHA_ONE - 1'b1;
      settings[2] = ALPHA_W'(32768);
      settings[3] = ALPHA_W'($urandom_range(65536));
      settings[4] = ALPHA_W'($urandom_range(131071, 65537));
      settings[5] = ALPHA_W'($urandom());
      foreach (settings[i]) begin
         write_filter_alpha(settings[i]);
         send_random_samples(PHASE_ITEMS);
      end
   endtask

   // A stretch in which neither side idles, so samples are offered back to back.
   task automatic test_steady_stream();
      write_filter_alpha(ALPHA_W'($urandom_range(65536)));
      no_idle = 1'b1;
      send_random_samples(200);
      drain_results();
      no_idle = 1'b0;
   endtask

   // The receiver holds off for a long stretch while samples keep coming, so
   // the output register fills and the block stalls its sample channel.
   task automatic test_output_hold();
      write_filter_alpha(ALPHA_RESET);
      hold_request = 1'b1;
      send_random_samples(40);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_weight_extremes();
      test_alpha_above_one();
      test_alpha_zero();
      test_random_weights();
      test_steady_stream();
      test_output_hold();

      // Everything must come back, and nothing extra may follow.
      drain_results();
      repeat (2 * LATENCY) @(posedge clock);

      $display("Covered %0d samples and %0d checked result beats over %0d weight settings,",
               samples_sent, results_checked, csr_writes);
      $display("with random idling, a steady stretch and %0d cycles of stalled input.",
               input_stall_cycles);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches, %0d results never arrived", errors,
                  pending_results.size());
         $display("FAILURE");
      end
      $finish;
   end

endmodule
